// ===== sv/avs_pkg.sv =====
package avs_pkg;

  localparam int MAX_KEYS = 64;
  localparam int KEY_BITS = 32;
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);

  typedef logic signed [KEY_BITS-1:0] key_t;
  typedef logic [CNT_W-1:0]           cnt_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } st_t;

  // broadcast control to every cell
  typedef struct packed {
    logic insert;
    logic drain;
  } avs_ctl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    key_t key;
    logic vld;
    logic below;   // incoming key belongs at or left of this cell
  } avs_lnk_t;

  localparam avs_lnk_t LNK_NONE = '{key: '0, vld: 1'b0, below: 1'b0};

endpackage

// ===== sv/ascending_value_sorter.sv =====
// Keys are accepted one per cycle while busy is low; each key is inserted
// into the sorted cell chain in the cycle it is accepted (dropped, with the
// drop flag set, if all cells are full). The first result appears the cycle
// after the closing key; stored keys drain smallest first, busy high.
// Throughput: one key per cycle while filling, one result per cycle draining.
// Reset (rst_n low, synchronous) empties all cells and clears count and drop flag.
module ascending_value_sorter import avs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_key_value,
  input  logic               in_set_end,
  output logic               out_valid,
  output logic signed [31:0] out_sorted_key,
  output logic               out_final_result,
  output logic               out_overflowed
);

  st_t      state_r, state_nxt;
  cnt_t     cnt_r, cnt_nxt;
  logic     drop_r, drop_nxt;
  logic     accept, room, last_out;
  avs_ctl_t ctl;
  key_t     new_key;
  avs_lnk_t lnk [MAX_KEYS];

  assign accept   = start && !busy;
  assign room     = cnt_r < CNT_W'(MAX_KEYS);
  assign last_out = (cnt_r == CNT_W'(1));
  assign new_key  = key_t'(in_key_value);

  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
    avs_lnk_t left_lnk, right_lnk;
    if (i == 0) begin : g_head
      assign left_lnk = LNK_NONE;
    end else begin : g_mid
      assign left_lnk = lnk[i-1];
    end
    if (i == MAX_KEYS - 1) begin : g_tail
      assign right_lnk = LNK_NONE;
    end else begin : g_body
      assign right_lnk = lnk[i+1];
    end
    avs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .new_key   (new_key),
      .left_lnk  (left_lnk),
      .right_lnk (right_lnk),
      .own_lnk   (lnk[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_FILL: begin
        if (accept && in_set_end) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (last_out) state_nxt = ST_FILL;
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    busy       = 1'b0;
    ctl.insert = 1'b0;
    ctl.drain  = 1'b0;
    cnt_nxt    = cnt_r;
    drop_nxt   = drop_r;
    unique case (state_r)
      ST_FILL: begin
        if (accept) begin
          if (room) begin
            ctl.insert = 1'b1;
            cnt_nxt    = cnt_r + CNT_W'(1);
          end else begin
            drop_nxt = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        busy      = 1'b1;
        ctl.drain = 1'b1;
        cnt_nxt   = cnt_r - CNT_W'(1);
        if (last_out) drop_nxt = 1'b0;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign out_valid        = (state_r == ST_DRAIN);
  assign out_sorted_key   = 32'(lnk[0].key);
  assign out_final_result = out_valid && last_out;
  assign out_overflowed   = out_valid && last_out && drop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
    end
  end

`ifndef SYNTHESIS
  a_out_has_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> lnk[0].vld)
    else $error("result strobe with empty head cell");

  a_final_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_final_result |=> !busy && !lnk[0].vld && cnt_r == '0)
    else $error("chain not empty after final result");

  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    !lnk[0].vld |-> !lnk[1].vld)
    else $error("hole at the head of the chain");

  a_drain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("draining with zero keys left");
`endif

endmodule

// ===== sv/avs_cell.sv =====
module avs_cell import avs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  avs_ctl_t ctl,
  input  key_t     new_key,
  input  avs_lnk_t left_lnk,
  input  avs_lnk_t right_lnk,
  output avs_lnk_t own_lnk
);

  key_t key_r, key_nxt;
  logic vld_r, vld_nxt;
  logic below;

  // empty cells act as +infinity
  assign below = !vld_r || (new_key < key_r);

  always_comb begin
    own_lnk.key   = key_r;
    own_lnk.vld   = vld_r;
    own_lnk.below = below;
  end

  always_comb begin
    key_nxt = key_r;
    vld_nxt = vld_r;
    if (ctl.drain) begin
      key_nxt = right_lnk.key;
      vld_nxt = right_lnk.vld;
    end else if (ctl.insert) begin
      if (left_lnk.below) begin
        // new key lands further left: make room
        key_nxt = left_lnk.key;
        vld_nxt = left_lnk.vld;
      end else if (below) begin
        key_nxt = new_key;
        vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

endmodule
